// ===== rtl/rrs_pkg.sv =====
// ----------------------------------------------------------------------------
// Resolution search package
// Shared widths, sizes, result codes and the queued item type.
// ----------------------------------------------------------------------------
`default_nettype none
package rrs_pkg;
   localparam int CLAUSE_MAX = 256;
   localparam int LIT_MAX    = 32;
   localparam int LIT_W      = 10;
   localparam int ROW_W      = 8;
   localparam int COL_W      = 5;
   localparam int TOTAL_W    = 9;
   localparam int LEN_W      = 6;
   localparam int ROUND_W    = 16;
   localparam int OUT_W      = 2;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W     = 2;
   localparam int QCNT_W     = 3;

   localparam logic [OUT_W-1:0] OUT_REFUTED   = 2'd0;
   localparam logic [OUT_W-1:0] OUT_SATURATED = 2'd1;
   localparam logic [OUT_W-1:0] OUT_EXHAUSTED = 2'd2;

   localparam logic [ROUND_W-1:0] ROUNDS_RESET = 16'd16;

   typedef struct packed {
      logic [LIT_W-1:0] literal;
      logic             literal_present;
      logic             clause_end;
      logic             formula_end;
   } item_type;
endpackage
`default_nettype wire

// ===== rtl/rrs_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module rrs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

// ===== rtl/rrs_front.sv =====
// ----------------------------------------------------------------------------
// Resolution search front end
// Accepts literal items and holds them in a short queue for the engine.
// ----------------------------------------------------------------------------
`default_nettype none
module rrs_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire rrs_pkg::item_type      item,
   input  wire logic                   pop,
   output logic                        q_valid,
   output rrs_pkg::item_type           q_item
);
   rrs_pkg::item_type q_ff [rrs_pkg::QUEUE_DEPTH];
   logic [rrs_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [rrs_pkg::QCNT_W-1:0] count_ff, count_in;
   logic push, pop_ok;

   assign busy    = (count_ff == rrs_pkg::QCNT_W'(rrs_pkg::QUEUE_DEPTH));
   assign push    = start && !busy;
   assign q_valid = (count_ff != '0);
   assign q_item  = q_ff[rd_ptr_ff];
   assign pop_ok  = pop && q_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + rrs_pkg::QPTR_W'(push);
      rd_ptr_in = rd_ptr_ff + rrs_pkg::QPTR_W'(pop_ok);
      count_in  = count_ff + rrs_pkg::QCNT_W'(push) - rrs_pkg::QCNT_W'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         q_ff[wr_ptr_ff] <= item;
      end
   end
endmodule
`default_nettype wire

// ===== rtl/rrs_back.sv =====
// ----------------------------------------------------------------------------
// Resolution search engine
// Loads clauses into the store and runs the pairwise resolution search.
// ----------------------------------------------------------------------------
`default_nettype none
module rrs_back (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              q_valid,
   input  wire rrs_pkg::item_type                 q_item,
   output logic                                   pop,
   input  wire logic                              csr_write_enable,
   input  wire logic [rrs_pkg::ROUND_W-1:0]       csr_write_data,
   output logic                                   rsp_valid,
   output logic [rrs_pkg::OUT_W-1:0]              rsp_outcome,
   output logic [rrs_pkg::TOTAL_W-1:0]            rsp_resolvent_count,
   output logic                                   rsp_overflow
);
   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_ROUND = 10'b0000000010,
      S_ICHK  = 10'b0000000100,
      S_ALEN  = 10'b0000001000,
      S_ALIT  = 10'b0000010000,
      S_JCHK  = 10'b0000100000,
      S_BLEN  = 10'b0001000000,
      S_BLIT  = 10'b0010000000,
      S_PIV   = 10'b0100000000,
      S_RES   = 10'b1000000000
   } state_type;

   localparam int AW = rrs_pkg::ROW_W + rrs_pkg::COL_W;
   localparam int VW = rrs_pkg::LIT_W - 1;

   state_type state_ff, state_in;
   logic [rrs_pkg::TOTAL_W-1:0] total_ff, total_in, count_ff, count_in;
   logic [rrs_pkg::TOTAL_W-1:0] i_ff, i_in, j_ff, j_in;
   logic [rrs_pkg::LEN_W-1:0]   load_len_ff, load_len_in, k_ff, k_in;
   logic [rrs_pkg::LEN_W-1:0]   na_ff, na_in, nb_ff, nb_in, n_ff, n_in;
   logic                        ovf_ff, ovf_in, progress_ff, progress_in;
   logic                        found_ff, found_in, phase_ff, phase_in;
   logic [1:0]                  pairs_ff, pairs_in;
   logic [VW-1:0]               pivot_ff, pivot_in;
   logic [rrs_pkg::ROUND_W-1:0] round_ff, round_in, max_rounds_ff;
   logic [rrs_pkg::LIT_W-1:0]   a_lit_ff [rrs_pkg::LIT_MAX];
   logic [rrs_pkg::LIT_W-1:0]   b_lit_ff [rrs_pkg::LIT_MAX];
   logic [rrs_pkg::LIT_W-1:0]   dst_ff   [rrs_pkg::LIT_MAX];
   logic                        rsp_valid_ff, rsp_valid_in, rsp_ovf_ff, rsp_ovf_in;
   logic [rrs_pkg::OUT_W-1:0]   rsp_outcome_ff, rsp_outcome_in;
   logic [rrs_pkg::TOTAL_W-1:0] rsp_count_ff, rsp_count_in;

   logic                        lit_we, len_we, cap_a, cap_b, put_dst;
   logic [AW-1:0]               lit_waddr, lit_raddr;
   logic [rrs_pkg::LIT_W-1:0]   lit_wdata, lit_rdata, cur_lit, cmp_lit;
   logic [rrs_pkg::ROW_W-1:0]   len_waddr, len_raddr;
   logic [rrs_pkg::LEN_W-1:0]   len_wdata, len_rdata, len_new, ns;
   logic [rrs_pkg::LIT_MAX-1:0] match, dup_vec;
   logic                        any_m, many_m, dup, closing;
   logic [1:0]                  m_cnt;

   rrs_ram #(.WIDTH(rrs_pkg::LIT_W), .DEPTH(rrs_pkg::CLAUSE_MAX * rrs_pkg::LIT_MAX))
      u_lit_ram (.clock(clock), .wr_en(lit_we), .wr_addr(lit_waddr), .wr_data(lit_wdata),
                 .rd_addr(lit_raddr), .rd_data(lit_rdata));

   rrs_ram #(.WIDTH(rrs_pkg::LEN_W), .DEPTH(rrs_pkg::CLAUSE_MAX))
      u_len_ram (.clock(clock), .wr_en(len_we), .wr_addr(len_waddr), .wr_data(len_wdata),
                 .rd_addr(len_raddr), .rd_data(len_rdata));

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_outcome         = rsp_outcome_ff;
   assign rsp_resolvent_count = rsp_count_ff;
   assign rsp_overflow        = rsp_ovf_ff;

   // Literal of clause i compared against all of clause j at once.
   always_comb begin
      cur_lit = a_lit_ff[k_ff[rrs_pkg::COL_W-1:0]];
      cmp_lit = {cur_lit[rrs_pkg::LIT_W-1:1], ~cur_lit[0]};
      ns      = phase_ff ? nb_ff : na_ff;
      if (phase_ff) begin
         cur_lit = b_lit_ff[k_ff[rrs_pkg::COL_W-1:0]];
      end
      for (int e = 0; e < rrs_pkg::LIT_MAX; e++) begin
         match[e]   = (rrs_pkg::LEN_W'(e) < nb_ff) && (b_lit_ff[e] == cmp_lit);
         dup_vec[e] = (rrs_pkg::LEN_W'(e) < n_ff) && (dst_ff[e] == cur_lit);
      end
      any_m  = |match;
      many_m = |(match & (match - rrs_pkg::LIT_MAX'(1)));
      m_cnt  = many_m ? 2'd2 : (any_m ? 2'd1 : 2'd0);
      dup    = |dup_vec;
   end

   always_comb begin
      state_in     = state_ff;
      total_in     = total_ff;
      count_in     = count_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      load_len_in  = load_len_ff;
      na_in        = na_ff;
      nb_in        = nb_ff;
      n_in         = n_ff;
      ovf_in       = ovf_ff;
      progress_in  = progress_ff;
      found_in     = found_ff;
      phase_in     = phase_ff;
      pairs_in     = pairs_ff;
      pivot_in     = pivot_ff;
      round_in     = round_ff;
      rsp_valid_in = 1'b0;
      rsp_outcome_in = rsp_outcome_ff;
      rsp_count_in = rsp_count_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      pop          = 1'b0;
      lit_we       = 1'b0;
      lit_waddr    = {total_ff[rrs_pkg::ROW_W-1:0], load_len_ff[rrs_pkg::COL_W-1:0]};
      lit_wdata    = q_item.literal;
      len_we       = 1'b0;
      len_waddr    = total_ff[rrs_pkg::ROW_W-1:0];
      len_wdata    = load_len_ff;
      len_raddr    = (state_ff == S_JCHK) ? j_ff[rrs_pkg::ROW_W-1:0]
                                          : i_ff[rrs_pkg::ROW_W-1:0];
      lit_raddr    = (state_ff == S_BLIT)
                   ? {j_ff[rrs_pkg::ROW_W-1:0], k_ff[rrs_pkg::COL_W-1:0]}
                   : {i_ff[rrs_pkg::ROW_W-1:0], k_ff[rrs_pkg::COL_W-1:0]};
      cap_a        = 1'b0;
      cap_b        = 1'b0;
      put_dst      = 1'b0;
      len_new      = load_len_ff;
      closing      = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               pop = 1'b1;
               if (q_item.literal_present) begin
                  if (load_len_ff < rrs_pkg::LEN_W'(rrs_pkg::LIT_MAX)) begin
                     lit_we  = !total_ff[rrs_pkg::TOTAL_W-1];
                     len_new = load_len_ff + 1'b1;
                  end else begin
                     ovf_in = 1'b1;
                  end
               end
               load_len_in = len_new;
               closing = q_item.clause_end || (q_item.formula_end && (len_new != '0));
               if (closing) begin
                  load_len_in = '0;
                  if (!total_ff[rrs_pkg::TOTAL_W-1]) begin
                     len_we    = 1'b1;
                     len_wdata = len_new;
                     total_in  = total_ff + 1'b1;
                  end else begin
                     ovf_in = 1'b1;
                  end
               end
               if (q_item.formula_end) begin
                  count_in = '0;
                  round_in = '0;
                  state_in = S_ROUND;
               end
            end
         end
         S_ROUND: begin
            if (round_ff == max_rounds_ff) begin
               rsp_valid_in   = 1'b1;
               rsp_outcome_in = rrs_pkg::OUT_EXHAUSTED;
               rsp_count_in   = count_ff;
               rsp_ovf_in     = ovf_ff;
               ovf_in         = 1'b0;
               total_in       = '0;
               load_len_in    = '0;
               state_in       = S_IDLE;
            end else begin
               progress_in = 1'b0;
               i_in        = '0;
               state_in    = S_ICHK;
            end
         end
         S_ICHK: begin
            if ((i_ff < total_ff) && !total_ff[rrs_pkg::TOTAL_W-1]) begin
               state_in = S_ALEN;
            end else if (!progress_ff) begin
               rsp_valid_in   = 1'b1;
               rsp_outcome_in = rrs_pkg::OUT_SATURATED;
               rsp_count_in   = count_ff;
               rsp_ovf_in     = ovf_ff;
               ovf_in         = 1'b0;
               total_in       = '0;
               load_len_in    = '0;
               state_in       = S_IDLE;
            end else begin
               round_in = round_ff + 1'b1;
               state_in = S_ROUND;
            end
         end
         S_ALEN: begin
            na_in    = len_rdata;
            k_in     = '0;
            state_in = S_ALIT;
         end
         S_ALIT: begin
            // Read data is registered and arrives in the cycle after its address.
            cap_a = (k_ff != '0);
            k_in  = k_ff + 1'b1;
            if (k_ff == rrs_pkg::LEN_W'(rrs_pkg::LIT_MAX)) begin
               j_in     = '0;
               state_in = S_JCHK;
            end
         end
         S_JCHK: begin
            if ((j_ff < total_ff) && !total_ff[rrs_pkg::TOTAL_W-1]) begin
               if (j_ff == i_ff) begin
                  j_in = j_ff + 1'b1;
               end else begin
                  state_in = S_BLEN;
               end
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = S_ICHK;
            end
         end
         S_BLEN: begin
            nb_in    = len_rdata;
            k_in     = '0;
            state_in = S_BLIT;
         end
         S_BLIT: begin
            cap_b = (k_ff != '0);
            k_in  = k_ff + 1'b1;
            if (k_ff == rrs_pkg::LEN_W'(rrs_pkg::LIT_MAX)) begin
               k_in     = '0;
               found_in = 1'b0;
               pairs_in = 2'd0;
               // The pivot scan walks the literals of clause i.
               phase_in = 1'b0;
               state_in = S_PIV;
            end
         end
         S_PIV: begin
            if (k_ff == na_ff) begin
               if (found_ff && (pairs_ff == 2'd1)) begin
                  k_in     = '0;
                  phase_in = 1'b0;
                  n_in     = '0;
                  state_in = S_RES;
               end else begin
                  j_in     = j_ff + 1'b1;
                  state_in = S_JCHK;
               end
            end else begin
               k_in = k_ff + 1'b1;
               if (!found_ff) begin
                  if (any_m) begin
                     found_in = 1'b1;
                     pivot_in = cur_lit[rrs_pkg::LIT_W-1:1];
                     pairs_in = m_cnt;
                  end
               end else if (cur_lit[rrs_pkg::LIT_W-1:1] == pivot_ff) begin
                  // Saturate: only "exactly one" matters.
                  pairs_in = ((3'(pairs_ff) + 3'(m_cnt)) > 3'd1) ? 2'd2
                                                                 : pairs_ff + m_cnt;
               end
            end
         end
         S_RES: begin
            if (k_ff == ns) begin
               if (!phase_ff) begin
                  phase_in = 1'b1;
                  k_in     = '0;
               end else begin
                  len_we      = 1'b1;
                  len_wdata   = n_ff;
                  total_in    = total_ff + 1'b1;
                  count_in    = count_ff + 1'b1;
                  progress_in = 1'b1;
                  if (n_ff == '0) begin
                     rsp_valid_in   = 1'b1;
                     rsp_outcome_in = rrs_pkg::OUT_REFUTED;
                     rsp_count_in   = count_ff + 1'b1;
                     rsp_ovf_in     = ovf_ff;
                     ovf_in         = 1'b0;
                     total_in       = '0;
                     load_len_in    = '0;
                     state_in       = S_IDLE;
                  end else begin
                     j_in     = j_ff + 1'b1;
                     state_in = S_JCHK;
                  end
               end
            end else begin
               k_in = k_ff + 1'b1;
               if ((cur_lit[rrs_pkg::LIT_W-1:1] != pivot_ff) && !dup &&
                   (n_ff < rrs_pkg::LEN_W'(rrs_pkg::LIT_MAX))) begin
                  put_dst   = 1'b1;
                  lit_we    = 1'b1;
                  lit_waddr = {total_ff[rrs_pkg::ROW_W-1:0], n_ff[rrs_pkg::COL_W-1:0]};
                  lit_wdata = cur_lit;
                  n_in      = n_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         total_ff      <= '0;
         load_len_ff   <= '0;
         ovf_ff        <= 1'b0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         max_rounds_ff <= rrs_pkg::ROUNDS_RESET;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         load_len_ff  <= load_len_in;
         ovf_ff       <= ovf_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            max_rounds_ff <= csr_write_data;
         end
      end
      i_ff           <= i_in;
      j_ff           <= j_in;
      k_ff           <= k_in;
      na_ff          <= na_in;
      nb_ff          <= nb_in;
      n_ff           <= n_in;
      progress_ff    <= progress_in;
      found_ff       <= found_in;
      phase_ff       <= phase_in;
      pairs_ff       <= pairs_in;
      pivot_ff       <= pivot_in;
      round_ff       <= round_in;
      rsp_outcome_ff <= rsp_outcome_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_ovf_ff     <= rsp_ovf_in;
      if (cap_a) begin
         a_lit_ff[k_ff[rrs_pkg::COL_W-1:0] - 1'b1] <= lit_rdata;
      end
      if (cap_b) begin
         b_lit_ff[k_ff[rrs_pkg::COL_W-1:0] - 1'b1] <= lit_rdata;
      end
      if (put_dst) begin
         dst_ff[n_ff[rrs_pkg::COL_W-1:0]] <= cur_lit;
      end
   end
endmodule
`default_nettype wire

// ===== rtl/resolution_refutation_search_unit.sv =====
// Search: a formula_end item is answered after the search, which reads each clause i, then
// each ordered pair (i, j), and writes the resolvent when the pair resolves; its duration is
// set by the single read port of the literal store that fills both clause registers serially.
// Throughput: one literal per cycle into a four-entry queue while the engine is loading.
// The result strobe rsp_valid lasts one cycle and cannot be stalled by the receiver.
// Reset: synchronous, clears the queue, control state, and sets max_rounds to 16.
// ----------------------------------------------------------------------------
// Resolution refutation search unit
// Top level: queue front end feeding the clause load and resolution engine.
// ----------------------------------------------------------------------------
`default_nettype none
module resolution_refutation_search_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic [rrs_pkg::LIT_W-1:0]         req_literal,
   input  wire logic                              req_literal_present,
   input  wire logic                              req_clause_end,
   input  wire logic                              req_formula_end,
   input  wire logic                              csr_write_enable,
   input  wire logic [rrs_pkg::ROUND_W-1:0]       csr_write_data,
   output logic                                   rsp_valid,
   output logic [rrs_pkg::OUT_W-1:0]              rsp_outcome,
   output logic [rrs_pkg::TOTAL_W-1:0]            rsp_resolvent_count,
   output logic                                   rsp_overflow
);
   rrs_pkg::item_type req_item, q_item;
   logic q_valid, pop;

   always_comb begin
      req_item.literal         = req_literal;
      req_item.literal_present = req_literal_present;
      req_item.clause_end      = req_clause_end;
      req_item.formula_end     = req_formula_end;
   end

   rrs_front u_front (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .item(req_item),
      .pop(pop), .q_valid(q_valid), .q_item(q_item)
   );

   rrs_back u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_item(q_item), .pop(pop),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .rsp_valid(rsp_valid), .rsp_outcome(rsp_outcome),
      .rsp_resolvent_count(rsp_resolvent_count), .rsp_overflow(rsp_overflow)
   );
endmodule
`default_nettype wire
